// ----- rtl/imuf_pkg.sv -----
// Shared constants, codes and the CORDIC angle table for the IMU attitude filter.
// No dependencies; used by the core, the checker and the testbench.
package imuf_pkg;

  localparam int CORDIC_STEPS    = 24;
  localparam int MAX_CAL_SAMPLES = 65536;

  localparam int RAW_W  = 16;
  localparam int CNT_W  = 17;
  localparam int SUM_W  = 33;
  localparam int OFF_W  = 26;
  localparam int ANG_W  = 32;
  localparam int CW     = 28;  // offset-corrected sample, 1/256 count
  localparam int XW     = 46;  // CORDIC x/y datapath
  localparam int MAW    = 33;  // multiplier operand a
  localparam int MBW    = 29;  // multiplier operand b
  localparam int PW     = 62;  // product
  localparam int DNW    = 64;  // divider dividend / quotient
  localparam int DDW    = 37;  // divider divisor
  localparam int QW     = 46;  // signed quotient kept
  localparam int GSW    = 47;  // gyro angle before saturation
  localparam int SQW    = 54;  // square root radicand
  localparam int SQ_STEPS = 27;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_CAL     = 2'd1;
  localparam logic [1:0] ST_NO_SAMPLES = 2'd2;
  localparam logic [1:0] ST_IGNORED    = 2'd3;

  localparam logic [1:0] REG_ACCEL_G    = 2'd0;
  localparam logic [1:0] REG_GYRO_SCALE = 2'd1;
  localparam logic [1:0] REG_BLEND      = 2'd2;
  localparam logic [1:0] REG_YAW_EN     = 2'd3;

  localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd11796480;
  localparam logic [20:0] US_PER_S = 21'd1000000;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/imuf_if.sv -----
// Valid/ready channel interfaces for the IMU attitude filter: samples in,
// results out, register writes. No dependencies.
interface imuf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [19:0]        elapsed_us;
  modport source (output valid, action, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                  gyro_z, elapsed_us, input ready);
  modport sink (input valid, action, accel_x, accel_y, accel_z, gyro_x, gyro_y,
                gyro_z, elapsed_us, output ready);
endinterface

interface imuf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_angle;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  logic [1:0]         status;
  logic               is_calibrated;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, status,
                  is_calibrated, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, status,
                is_calibrated, output ready);
endinterface

interface imuf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/imu_complementary_attitude_filter_core.sv -----
// Sample, refused and ignored requests go straight to the result state; update
// runs longer with accel yaw enabled and skips a CORDIC pass with y input zero.
// One request at a time: ready is high only while idle. The time is set by the
// shared 64-step radix-2 divider, plus the 24-step CORDIC and 27-step square root.
// Reset (rst, synchronous): registers to defaults, sums/offsets/angles cleared,
// uncalibrated, seed pending. Uses imuf_pkg and the interfaces in imuf_if.sv.
module imu_complementary_attitude_filter_core (
  input  logic       clk,
  input  logic       rst,
  imuf_in_if.sink    sample,
  imuf_out_if.source result,
  imuf_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_CORD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [4:0] P_DEN   = 5'd0;
  localparam logic [4:0] P_SQA   = 5'd1;
  localparam logic [4:0] P_SQB   = 5'd2;
  localparam logic [4:0] P_SQRT  = 5'd3;
  localparam logic [4:0] P_ROLL  = 5'd4;
  localparam logic [4:0] P_PITCH = 5'd5;
  localparam logic [4:0] P_YAWA  = 5'd6;
  localparam logic [4:0] P_YAWB  = 5'd7;
  localparam logic [4:0] P_YAWS  = 5'd8;
  localparam logic [4:0] P_YAWC  = 5'd9;
  localparam logic [4:0] P_YAWD  = 5'd10;
  localparam logic [4:0] P_SEED  = 5'd11;
  localparam logic [4:0] P_GMUL  = 5'd12;
  localparam logic [4:0] P_GDIV  = 5'd13;
  localparam logic [4:0] P_GINT  = 5'd14;
  localparam logic [4:0] P_BLA   = 5'd15;
  localparam logic [4:0] P_BLB   = 5'd16;
  localparam logic [4:0] P_FDIV  = 5'd17;
  localparam logic [4:0] P_FST   = 5'd18;

  logic [2:0] state;
  logic [4:0] pc;
  logic [2:0] axis;

  // registers
  logic [15:0] accel_g;
  logic [15:0] gyro_scale;
  logic [16:0] blend_w;
  logic        yaw_en;

  // filter state
  logic signed [imuf_pkg::SUM_W-1:0] sums [6];
  logic [imuf_pkg::CNT_W-1:0]        cal_count;
  logic signed [imuf_pkg::OFF_W-1:0] offsets [6];
  logic signed [imuf_pkg::ANG_W-1:0] gyro_ang [3];
  logic signed [imuf_pkg::ANG_W-1:0] blended [3];
  logic signed [imuf_pkg::ANG_W-1:0] acc_roll, acc_pitch, acc_yaw;
  logic                              seed_pending;
  logic                              calibrated;

  // per-request working registers
  logic signed [imuf_pkg::CW-1:0] c [6];
  logic [19:0]                    us;
  logic [1:0]                     st;

  logic signed [imuf_pkg::MAW-1:0] mul_a;
  logic signed [imuf_pkg::MBW-1:0] mul_b;
  logic signed [imuf_pkg::PW-1:0]  prod, sq, bt;
  logic [imuf_pkg::DDW-1:0]        den;

  logic [imuf_pkg::DNW-1:0] dnum;
  logic [imuf_pkg::DDW-1:0] drem, dden;
  logic                     dneg;
  logic [5:0]               dcnt;

  logic [imuf_pkg::SQW-1:0] sv, sres, sbit;
  logic [4:0]               scnt;

  logic signed [imuf_pkg::XW-1:0]    cx, cy;
  logic signed [imuf_pkg::ANG_W-1:0] cz;
  logic [4:0]                        ccnt;

  logic out_valid;
  logic signed [imuf_pkg::ANG_W-1:0] out_roll, out_pitch, out_yaw;
  logic [1:0] out_status;
  logic       out_cal;

  // combinational helpers
  logic signed [imuf_pkg::RAW_W-1:0] raw_in [6];
  logic signed [imuf_pkg::CW-1:0]    c_in [6];
  logic [15:0]                       gs_eff;
  logic [16:0]                       w_eff, w_rest;
  logic signed [imuf_pkg::CW-1:0]    root;
  logic signed [imuf_pkg::CW-1:0]    cord_y_in, cord_x_in;
  logic signed [imuf_pkg::XW-1:0]    cord_xe, cord_ye;
  logic signed [imuf_pkg::ANG_W-1:0] cord_z0;
  logic signed [imuf_pkg::XW-1:0]    cxs, cys;
  logic [imuf_pkg::DDW:0]            rem_sh;
  logic                              qbit;
  logic [imuf_pkg::SQW-1:0]          trial;
  logic [imuf_pkg::PW-1:0]           prod_mag;
  logic [imuf_pkg::SUM_W-1:0]        sum_mag;
  logic signed [imuf_pkg::QW-1:0]    q_mag, qs, off_full;
  logic signed [imuf_pkg::GSW-1:0]   g_sum;
  logic signed [imuf_pkg::ANG_W-1:0] gsat, acc_sel;
  logic signed [imuf_pkg::PW-1:0]    blend_sum;

  assign raw_in[0] = sample.accel_x;
  assign raw_in[1] = sample.accel_y;
  assign raw_in[2] = sample.accel_z;
  assign raw_in[3] = sample.gyro_x;
  assign raw_in[4] = sample.gyro_y;
  assign raw_in[5] = sample.gyro_z;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      c_in[k] = (imuf_pkg::CW'(raw_in[k]) <<< 8) - imuf_pkg::CW'(offsets[k]);
    end
  end

  assign gs_eff = (gyro_scale == 16'd0) ? 16'd1 : gyro_scale;
  assign w_eff  = (blend_w > 17'd65536) ? 17'd65536 : blend_w;
  assign w_rest = 17'd65536 - w_eff;
  assign root   = $signed(sres[imuf_pkg::CW-1:0]);

  always_comb begin
    case (pc)
      P_ROLL:  begin cord_y_in = c[1];  cord_x_in = c[2]; end
      P_PITCH: begin cord_y_in = -c[0]; cord_x_in = root; end
      P_YAWC:  begin cord_y_in = c[2];  cord_x_in = root; end
      default: begin cord_y_in = '0;    cord_x_in = '0;   end
    endcase
  end

  assign cord_xe = cord_x_in[imuf_pkg::CW-1] ? -(imuf_pkg::XW'(cord_x_in) <<< 14)
                                             : (imuf_pkg::XW'(cord_x_in) <<< 14);
  assign cord_ye = cord_x_in[imuf_pkg::CW-1] ? -(imuf_pkg::XW'(cord_y_in) <<< 14)
                                             : (imuf_pkg::XW'(cord_y_in) <<< 14);
  assign cord_z0 = !cord_x_in[imuf_pkg::CW-1] ? '0 :
                   (cord_y_in[imuf_pkg::CW-1] ? -imuf_pkg::ANG_180 : imuf_pkg::ANG_180);

  assign cxs = cx >>> ccnt;
  assign cys = cy >>> ccnt;

  assign rem_sh = {drem, dnum[imuf_pkg::DNW-1]};
  assign qbit   = (rem_sh >= {1'b0, dden});
  assign trial  = sres + sbit;

  assign prod_mag = prod[imuf_pkg::PW-1] ? $unsigned(-prod) : $unsigned(prod);
  assign sum_mag  = sums[axis][imuf_pkg::SUM_W-1] ? $unsigned(-sums[axis])
                                                  : $unsigned(sums[axis]);

  assign q_mag    = $signed({1'b0, dnum[imuf_pkg::QW-2:0]});
  assign qs       = dneg ? -q_mag : q_mag;
  assign off_full = qs - ((axis == 3'd2) ? imuf_pkg::QW'({accel_g, 8'd0}) : '0);

  assign g_sum = imuf_pkg::GSW'(gyro_ang[axis[1:0]]) + imuf_pkg::GSW'(qs);
  assign gsat  = (g_sum > imuf_pkg::GSW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                 (g_sum < -imuf_pkg::GSW'(33'sh080000000)) ? 32'sh80000000 :
                 g_sum[imuf_pkg::ANG_W-1:0];

  always_comb begin
    case (axis[1:0])
      2'd0:    acc_sel = acc_roll;
      2'd1:    acc_sel = acc_pitch;
      default: acc_sel = acc_yaw;
    endcase
  end

  assign blend_sum = bt + prod + imuf_pkg::PW'(32768);

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign result.valid         = out_valid;
  assign result.roll_angle    = out_roll;
  assign result.pitch_angle   = out_pitch;
  assign result.yaw_angle     = out_yaw;
  assign result.status        = out_status;
  assign result.is_calibrated = out_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= P_DEN;
      axis         <= '0;
      accel_g      <= 16'd16384;
      gyro_scale   <= 16'd33536;
      blend_w      <= 17'd64225;
      yaw_en       <= 1'b0;
      cal_count    <= '0;
      acc_yaw      <= '0;
      seed_pending <= 1'b1;
      calibrated   <= 1'b0;
      out_valid    <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        sums[k]    <= '0;
        offsets[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        gyro_ang[k] <= '0;
        blended[k]  <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          imuf_pkg::REG_ACCEL_G:    accel_g    <= cfg.data[15:0];
          imuf_pkg::REG_GYRO_SCALE: gyro_scale <= cfg.data[15:0];
          imuf_pkg::REG_BLEND:      blend_w    <= cfg.data;
          imuf_pkg::REG_YAW_EN:     yaw_en     <= cfg.data[0];
          default: ;
        endcase
      end
      if (out_valid && result.ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            for (int k = 0; k < 6; k++) c[k] <= c_in[k];
            us   <= sample.elapsed_us;
            st   <= imuf_pkg::ST_OK;
            axis <= '0;
            state <= S_DONE;
            case (sample.action)
              imuf_pkg::ACT_SAMPLE: begin
                if (cal_count < imuf_pkg::CNT_W'(imuf_pkg::MAX_CAL_SAMPLES)) begin
                  for (int k = 0; k < 6; k++)
                    sums[k] <= sums[k] + imuf_pkg::SUM_W'(raw_in[k]);
                  cal_count <= cal_count + 1'b1;
                end else begin
                  st <= imuf_pkg::ST_IGNORED;
                end
              end
              imuf_pkg::ACT_FINISH: begin
                if (cal_count == '0) begin
                  st <= imuf_pkg::ST_NO_SAMPLES;
                end else begin
                  pc    <= P_FDIV;
                  state <= S_STEP;
                end
              end
              imuf_pkg::ACT_UPDATE: begin
                if (!calibrated) begin
                  st <= imuf_pkg::ST_NO_CAL;
                end else begin
                  pc    <= P_DEN;
                  state <= S_STEP;
                end
              end
              default: ;
            endcase
          end
        end

        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_STEP;
        end

        S_DIV: begin
          drem <= qbit ? imuf_pkg::DDW'(rem_sh - {1'b0, dden})
                       : rem_sh[imuf_pkg::DDW-1:0];
          dnum <= {dnum[imuf_pkg::DNW-2:0], qbit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd63) state <= S_STEP;
        end

        S_SQRT: begin
          if (sv >= trial) begin
            sv   <= sv - trial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 1'b1;
          if (scnt == 5'(imuf_pkg::SQ_STEPS - 1)) state <= S_STEP;
        end

        S_CORD: begin
          if (cy > 0) begin
            cx <= cx + cys;
            cy <= cy - cxs;
            cz <= cz + imuf_pkg::atan_entry(ccnt);
          end else begin
            cx <= cx - cys;
            cy <= cy + cxs;
            cz <= cz - imuf_pkg::atan_entry(ccnt);
          end
          ccnt <= ccnt + 1'b1;
          if (ccnt == 5'(imuf_pkg::CORDIC_STEPS - 1)) state <= S_STEP;
        end

        S_STEP: begin
          unique case (pc)
            P_DEN: begin
              mul_a <= imuf_pkg::MAW'(imuf_pkg::US_PER_S);
              mul_b <= imuf_pkg::MBW'(gs_eff);
              pc <= P_SQA; state <= S_MUL;
            end
            P_SQA: begin
              den   <= prod[imuf_pkg::DDW-1:0];
              mul_a <= imuf_pkg::MAW'(c[1]);
              mul_b <= imuf_pkg::MBW'(c[1]);
              pc <= P_SQB; state <= S_MUL;
            end
            P_SQB: begin
              sq    <= prod;
              mul_a <= imuf_pkg::MAW'(c[2]);
              mul_b <= imuf_pkg::MBW'(c[2]);
              pc <= P_SQRT; state <= S_MUL;
            end
            P_SQRT, P_YAWS: begin
              sv   <= imuf_pkg::SQW'(sq + prod);
              sres <= '0;
              sbit <= imuf_pkg::SQW'(1) << (imuf_pkg::SQW - 2);
              scnt <= '0;
              pc <= (pc == P_SQRT) ? P_ROLL : P_YAWC;
              state <= S_SQRT;
            end
            P_ROLL, P_PITCH, P_YAWC: begin
              if (pc == P_PITCH) acc_roll <= cz;
              cx   <= cord_xe;
              cy   <= cord_ye;
              cz   <= cord_z0;
              ccnt <= '0;
              pc <= (pc == P_ROLL) ? P_PITCH : ((pc == P_PITCH) ? P_YAWA : P_YAWD);
              state <= (cord_y_in == '0) ? S_STEP : S_CORD;
            end
            P_YAWA: begin
              acc_pitch <= cz;
              if (yaw_en) begin
                mul_a <= imuf_pkg::MAW'(c[0]);
                mul_b <= imuf_pkg::MBW'(c[0]);
                pc <= P_YAWB; state <= S_MUL;
              end else begin
                pc <= P_SEED;
              end
            end
            P_YAWB: begin
              sq    <= prod;
              mul_a <= imuf_pkg::MAW'(c[1]);
              mul_b <= imuf_pkg::MBW'(c[1]);
              pc <= P_YAWS; state <= S_MUL;
            end
            P_YAWD: begin
              acc_yaw <= cz;
              pc <= P_SEED;
            end
            P_SEED: begin
              if (seed_pending) begin
                gyro_ang[0]  <= acc_roll;
                gyro_ang[1]  <= acc_pitch;
                gyro_ang[2]  <= acc_yaw;
                seed_pending <= 1'b0;
              end
              axis <= '0;
              pc <= P_GMUL;
            end
            P_GMUL: begin
              mul_a <= imuf_pkg::MAW'(c[3'd3 + axis]);
              mul_b <= imuf_pkg::MBW'({1'b0, us});
              pc <= P_GDIV; state <= S_MUL;
            end
            P_GDIV: begin
              dnum <= {prod_mag[imuf_pkg::DNW-17:0], 16'd0}
                      + imuf_pkg::DNW'(den >> 1);
              dden <= den;
              dneg <= prod[imuf_pkg::PW-1];
              drem <= '0;
              dcnt <= '0;
              pc <= P_GINT; state <= S_DIV;
            end
            P_GINT: begin
              gyro_ang[axis[1:0]] <= gsat;
              mul_a <= imuf_pkg::MAW'(gsat);
              mul_b <= imuf_pkg::MBW'(w_eff);
              pc <= P_BLA; state <= S_MUL;
            end
            P_BLA: begin
              bt    <= prod;
              mul_a <= imuf_pkg::MAW'(acc_sel);
              mul_b <= imuf_pkg::MBW'(w_rest);
              pc <= P_BLB; state <= S_MUL;
            end
            P_BLB: begin
              blended[axis[1:0]] <= blend_sum[47:16];
              if (axis == 3'd2) begin
                state <= S_DONE;
              end else begin
                axis <= axis + 1'b1;
                pc   <= P_GMUL;
              end
            end
            P_FDIV: begin
              dnum <= imuf_pkg::DNW'({sum_mag, 8'd0}) + imuf_pkg::DNW'(cal_count >> 1);
              dden <= imuf_pkg::DDW'(cal_count);
              dneg <= sums[axis][imuf_pkg::SUM_W-1];
              drem <= '0;
              dcnt <= '0;
              pc <= P_FST; state <= S_DIV;
            end
            P_FST: begin
              offsets[axis] <= off_full[imuf_pkg::OFF_W-1:0];
              if (axis == 3'd5) begin
                for (int k = 0; k < 6; k++) sums[k] <= '0;
                cal_count  <= '0;
                calibrated <= 1'b1;
                state      <= S_DONE;
              end else begin
                axis <= axis + 1'b1;
                pc   <= P_FDIV;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_roll   <= blended[0];
            out_pitch  <= blended[1];
            out_yaw    <= blended[2];
            out_status <= st;
            out_cal    <= calibrated;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/imuf_checker.sv -----
// Port-level checks for the IMU attitude filter core, bound into the core module.
// Depends on imuf_pkg and the channel interfaces of the core.
module imuf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] out_roll,
  input logic [1:0]        out_status,
  input logic              out_cal
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_roll) && $stable(out_status))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_nocal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == imuf_pkg::ST_NO_CAL) |-> !out_cal)
    else $error("refused update reported as calibrated");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind imu_complementary_attitude_filter_core imuf_checker u_imuf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample.valid),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_roll   (result.roll_angle),
  .out_status (result.status),
  .out_cal    (result.is_calibrated)
);

// ----- tb/testbench.sv -----
// Self-checking bench for imu_complementary_attitude_filter_core: directed table,
// then random phases over register settings; all but the first directed rows are
// checked against an in-bench attitude predictor. Needs imuf_pkg and imuf_if.sv.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [1:0]         act;
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic [19:0]        us;
  } imu_req_t;

  typedef struct {
    logic signed [31:0] roll, pitch, yaw;
    logic [1:0]         st;
    logic               cal;
  } attitude_t;

  typedef struct {
    imu_req_t  req;
    bit        typed;
    attitude_t want;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  imuf_in_if  sample();
  imuf_out_if result();
  imuf_cfg_if cfg();

  imu_complementary_attitude_filter_core u_dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result), .cfg(cfg)
  );

  // predictor state
  logic [15:0] p_accel_g;
  logic [15:0] p_gyro_scale;
  logic [16:0] p_blend;
  bit          p_yaw_en;
  longint      cal_sums[6];
  int unsigned cal_cnt;
  longint      offs[6];
  longint      gyro_ang[3];
  longint      blend_ang[3];
  longint      accel_yaw;
  bit          seed_pend;
  bit          calib;

  attitude_t   attitude_q[$];
  int          errors = 0;
  int          stall_cnt = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b0;
  int          burst_left = 0;

  const longint atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint div_round(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return (x < 0) ? longint'(imuf_pkg::ANG_180) : 0;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      z = (y >= 0) ? longint'(imuf_pkg::ANG_180) : -longint'(imuf_pkg::ANG_180);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < imuf_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_steps[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_steps[i];
      end
    end
    return z;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_attitude(input imu_req_t r, output attitude_t o);
    longint raw[6], c[6], acc[3], inc, w;
    longint unsigned gs, den;
    logic [1:0] st;
    raw[0] = r.ax; raw[1] = r.ay; raw[2] = r.az;
    raw[3] = r.gx; raw[4] = r.gy; raw[5] = r.gz;
    st = imuf_pkg::ST_OK;
    case (r.act)
      imuf_pkg::ACT_SAMPLE: begin
        if (cal_cnt < imuf_pkg::MAX_CAL_SAMPLES) begin
          for (int i = 0; i < 6; i++) cal_sums[i] += raw[i];
          cal_cnt++;
        end else begin
          st = imuf_pkg::ST_IGNORED;
        end
      end
      imuf_pkg::ACT_FINISH: begin
        if (cal_cnt == 0) begin
          st = imuf_pkg::ST_NO_SAMPLES;
        end else begin
          for (int i = 0; i < 6; i++) begin
            offs[i] = div_round(cal_sums[i] * 256, cal_cnt);
            cal_sums[i] = 0;
          end
          offs[2] -= longint'(p_accel_g) * 256;
          cal_cnt = 0;
          calib = 1'b1;
        end
      end
      imuf_pkg::ACT_UPDATE: begin
        if (!calib) begin
          st = imuf_pkg::ST_NO_CAL;
        end else begin
          gs = (p_gyro_scale == 0) ? 1 : p_gyro_scale;
          den = gs * 1000000;
          w = (p_blend > 17'd65536) ? 65536 : longint'(p_blend);
          for (int i = 0; i < 6; i++) c[i] = raw[i] * 256 - offs[i];
          acc[0] = angle_of(c[1], c[2]);
          acc[1] = angle_of(-c[0], longint'(root_floor(c[1] * c[1] + c[2] * c[2])));
          if (p_yaw_en)
            accel_yaw = angle_of(c[2], longint'(root_floor(c[0] * c[0] + c[1] * c[1])));
          acc[2] = accel_yaw;
          if (seed_pend) begin
            for (int i = 0; i < 3; i++) gyro_ang[i] = acc[i];
            seed_pend = 1'b0;
          end
          for (int i = 0; i < 3; i++) begin
            inc = div_round(c[3 + i] * 65536 * longint'(r.us), den);
            gyro_ang[i] = clamp32(gyro_ang[i] + inc);
            blend_ang[i] = (w * gyro_ang[i] + (65536 - w) * acc[i] + 32768) >>> 16;
          end
        end
      end
      default: ;
    endcase
    o.roll = blend_ang[0][31:0];
    o.pitch = blend_ang[1][31:0];
    o.yaw = blend_ang[2][31:0];
    o.st = st;
    o.cal = calib;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_request(input imu_req_t r, input bit typed, input attitude_t want);
    int gap;
    attitude_t o;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (idle_on) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.action <= r.act;
    sample.accel_x <= r.ax; sample.accel_y <= r.ay; sample.accel_z <= r.az;
    sample.gyro_x <= r.gx; sample.gyro_y <= r.gy; sample.gyro_z <= r.gz;
    sample.elapsed_us <= r.us;
    do @(posedge clk); while (!sample.ready);
    predict_attitude(r, o);
    attitude_q.push_back(typed ? want : o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    sample.valid <= 1'b0;
    wait (attitude_q.size() == 0);
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      imuf_pkg::REG_ACCEL_G:    p_accel_g = val[15:0];
      imuf_pkg::REG_GYRO_SCALE: p_gyro_scale = val[15:0];
      imuf_pkg::REG_BLEND:      p_blend = val;
      default:                  p_yaw_en = val[0];
    endcase
  endtask

  function automatic imu_req_t mk(logic [1:0] a, int ax, int ay, int az,
                                  int gx, int gy, int gz, int us);
    imu_req_t r;
    r.act = a; r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
    r.gx = 16'(gx); r.gy = 16'(gy); r.gz = 16'(gz); r.us = 20'(us);
    return r;
  endfunction

  function automatic imu_req_t rand_req(logic [1:0] a);
    imu_req_t r;
    r.act = a;
    if ($urandom_range(0, 1)) begin
      {r.ax, r.ay, r.az} = 48'({$urandom, $urandom});
      {r.gx, r.gy, r.gz} = 48'({$urandom, $urandom});
    end else begin
      r.ax = 16'($signed($urandom_range(0, 4000)) - 2000);
      r.ay = 16'($signed($urandom_range(0, 4000)) - 2000);
      r.az = 16'($signed($urandom_range(0, 4000)) + 14000);
      r.gx = 16'($signed($urandom_range(0, 600)) - 300);
      r.gy = 16'($signed($urandom_range(0, 600)) - 300);
      r.gz = 16'($signed($urandom_range(0, 600)) - 300);
    end
    case ($urandom_range(0, 9))
      0: r.us = 20'd0;
      1: r.us = 20'hFFFFF;
      2: r.us = 20'($urandom);
      default: r.us = 20'($urandom_range(5000, 15000));
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    attitude_t w;
    stall_cnt++;
    if (rst) result.ready <= 1'b1;
    else result.ready <= !idle_on || ((stall_cnt % 11) > 2 && $urandom_range(0, 5) != 0);
    if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && result.valid && result.ready) begin
      if (attitude_q.size() == 0) begin
        report("unexpected result", result.status, -1);
      end else begin
        w = attitude_q.pop_front();
        if (result.roll_angle !== w.roll) report("roll", result.roll_angle, w.roll);
        if (result.pitch_angle !== w.pitch) report("pitch", result.pitch_angle, w.pitch);
        if (result.yaw_angle !== w.yaw) report("yaw", result.yaw_angle, w.yaw);
        if (result.status !== w.st) report("status", result.status, w.st);
        if (result.is_calibrated !== w.cal) report("calibrated", result.is_calibrated, w.cal);
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t d;
    attitude_t z;
    imu_req_t r;
    int n, k;
    sample.valid = 1'b0; sample.action = imuf_pkg::ACT_SAMPLE;
    sample.accel_x = 0; sample.accel_y = 0; sample.accel_z = 0;
    sample.gyro_x = 0; sample.gyro_y = 0; sample.gyro_z = 0; sample.elapsed_us = 0;
    cfg.valid = 1'b0; cfg.index = imuf_pkg::REG_ACCEL_G; cfg.data = 0;
    p_accel_g = 16384; p_gyro_scale = 33536; p_blend = 64225; p_yaw_en = 0;
    for (int i = 0; i < 6; i++) begin cal_sums[i] = 0; offs[i] = 0; end
    for (int i = 0; i < 3; i++) begin gyro_ang[i] = 0; blend_ang[i] = 0; end
    cal_cnt = 0; accel_yaw = 0; seed_pend = 1; calib = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    z = '{roll: 0, pitch: 0, yaw: 0, st: imuf_pkg::ST_NO_CAL, cal: 0};
    d.typed = 1;
    d.want = z;
    d.req = mk(imuf_pkg::ACT_UPDATE, 100, 200, 16384, 5, 5, 5, 10000); rows.push_back(d);
    z.st = imuf_pkg::ST_NO_SAMPLES;
    d.want = z; d.req = mk(imuf_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
    z.st = imuf_pkg::ST_OK;
    d.want = z;
    d.req = mk(imuf_pkg::ACT_NOP, -1, -1, -1, -1, -1, -1, 20'hFFFFF); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_SAMPLE, 32767, 32767, 32767, 32767, 32767, 32767, 20'hFFFFF);
    rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_SAMPLE, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_SAMPLE, 0, 0, 16384, 3, -3, 1, 0); rows.push_back(d);
    d.typed = 0;
    d.req = mk(imuf_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 0, 0, 16384, 0, 0, 0, 10000); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 500, -500, 16000, 100, -100, 50, 0); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 0, 0, 16384, 32767, 32767, 32767, 20'hFFFFF);
    rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 0, 0, 16384, -32768, -32768, -32768, 20'hFFFFF);
    rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, -32768, 32767, -32768, 0, 0, 0, 1000); rows.push_back(d);
    // recalibrate on a single level sample so corrected y can be exactly zero
    d.req = mk(imuf_pkg::ACT_SAMPLE, 0, 0, 16384, 0, 0, 0, 0); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 0, 0, 16384, 0, 0, 0, 10000); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 0, 0, -16384, 0, 0, 0, 10000); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 0, 0, 0, 0, 0, 0, 10000); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_UPDATE, 16384, 0, 0, 0, 0, 0, 10000); rows.push_back(d);
    d.req = mk(imuf_pkg::ACT_NOP, 7, 7, 7, 7, 7, 7, 7); rows.push_back(d);
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);

    send_request(mk(imuf_pkg::ACT_FINISH, 0, 0, 0, 0, 0, 0, 0), 0, z);
    send_request(rand_req(imuf_pkg::ACT_UPDATE), 0, z);

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3) != 2;
      case (ph)
        0: begin
          write_reg(imuf_pkg::REG_ACCEL_G, 17'd1);
          write_reg(imuf_pkg::REG_GYRO_SCALE, 17'd1);
          write_reg(imuf_pkg::REG_BLEND, 17'd0);
          write_reg(imuf_pkg::REG_YAW_EN, 17'd1);
        end
        1: begin
          write_reg(imuf_pkg::REG_ACCEL_G, 17'd32768);
          write_reg(imuf_pkg::REG_GYRO_SCALE, 17'd65535);
          write_reg(imuf_pkg::REG_BLEND, 17'd65536);
          write_reg(imuf_pkg::REG_YAW_EN, 17'd0);
        end
        2: begin
          write_reg(imuf_pkg::REG_GYRO_SCALE, 17'd0);
          write_reg(imuf_pkg::REG_BLEND, 17'h1FFFF);
          write_reg(imuf_pkg::REG_YAW_EN, 17'd1);
        end
        3: begin
          write_reg(imuf_pkg::REG_ACCEL_G, 17'd16384);
          write_reg(imuf_pkg::REG_GYRO_SCALE, 17'd33536);
          write_reg(imuf_pkg::REG_BLEND, 17'd64225);
          write_reg(imuf_pkg::REG_YAW_EN, 17'd0);
        end
        default: begin
          write_reg(imuf_pkg::REG_ACCEL_G, 17'($urandom_range(1, 32768)));
          write_reg(imuf_pkg::REG_GYRO_SCALE, 17'($urandom_range(0, 65535)));
          write_reg(imuf_pkg::REG_BLEND, 17'($urandom));
          write_reg(imuf_pkg::REG_YAW_EN, 17'($urandom_range(0, 1)));
        end
      endcase
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) send_request(rand_req(imuf_pkg::ACT_SAMPLE), 0, z);
      send_request(rand_req(imuf_pkg::ACT_FINISH), 0, z);
      for (int i = 0; i < 140; i++) begin
        k = $urandom_range(0, 19);
        if (k == 0) r = rand_req(imuf_pkg::ACT_SAMPLE);
        else if (k == 1) r = rand_req(imuf_pkg::ACT_FINISH);
        else if (k == 2) r = rand_req(imuf_pkg::ACT_NOP);
        else r = rand_req(imuf_pkg::ACT_UPDATE);
        send_request(r, 0, z);
      end
    end

    sample.valid <= 1'b0;
    wait (attitude_q.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/imuf_pkg.sv
rtl/imuf_if.sv
rtl/imu_complementary_attitude_filter_core.sv
rtl/imuf_checker.sv
tb/testbench.sv
